>>> rtl/mrts_pkg.sv
// ----------------------------------------------------------------------------
// mrts_pkg
// Shared types and constants of the minimum-runtime task scheduler.
// ----------------------------------------------------------------------------
package mrts_pkg;

   // default sizing
   localparam int TASK_COUNT_DEF   = 16;
   localparam int RUNTIME_BITS_DEF = 32;
   localparam int SLICE_W          = 16;
   localparam int TASK_ID_W        = 4;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

   // operation codes
   localparam logic [1:0] OP_ACTIVATE = 2'd0;
   localparam logic [1:0] OP_RESCHED  = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;

   // task state codes
   localparam logic [2:0] ST_UNUSED   = 3'd0;
   localparam logic [2:0] ST_RUNNABLE = 3'd1;
   localparam logic [2:0] ST_RUNNING  = 3'd2;
   localparam logic [2:0] ST_SLEEPING = 3'd3;
   localparam logic [2:0] ST_DEEP     = 3'd4;
   localparam logic [2:0] ST_ZOMBIE   = 3'd5;

   // reschedule target codes as carried in target_state
   localparam logic [1:0] TGT_RUNNABLE = 2'd0;
   localparam logic [1:0] TGT_SLEEPING = 2'd1;
   localparam logic [1:0] TGT_DEEP     = 2'd2;
   localparam logic [1:0] TGT_ZOMBIE   = 2'd3;

   // request transaction
   typedef struct packed {
      logic [1:0]           op;
      logic [TASK_ID_W-1:0] task_id;
      logic                 on_alert;
      logic [1:0]           target_state;
      logic                 running_killed;
   } req_type;

   // response transaction
   typedef struct packed {
      logic                 accepted;
      logic [TASK_ID_W-1:0] running_task;
      logic                 switched;
   } rsp_type;

   // read address source of the task tables
   typedef enum logic [1:0] {
      RD_TID,
      RD_CUR,
      RD_SCAN
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       act_commit;
      logic       tick_commit;
      logic       apply_commit;
      logic       scan_start;
      logic       scan_step;
      logic       pick_commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       res_blocked;
      logic       scan_last;
   } sts_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_ACT_EVAL,
      S_TICK_ADD,
      S_RES_APPLY,
      S_SCAN,
      S_DRAIN,
      S_PICK,
      S_DONE
   } ctl_state_type;

   // target_state field to stored state code
   function automatic logic [2:0] target_code(input logic [1:0] tgt);
      logic [2:0] code;
      unique case (tgt)
         TGT_RUNNABLE: code = ST_RUNNABLE;
         TGT_SLEEPING: code = ST_SLEEPING;
         TGT_DEEP:     code = ST_DEEP;
         TGT_ZOMBIE:   code = ST_ZOMBIE;
         default:      code = ST_RUNNABLE;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/mrts_ctrl.sv
// ----------------------------------------------------------------------------
// mrts_ctrl
// Sequencing state machine: dispatches each request, steps the ready-set
// scan and raises the response strobe.
// ----------------------------------------------------------------------------
module mrts_ctrl
   import mrts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.op)
               OP_ACTIVATE: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_TID;
                  state_in   = S_ACT_EVAL;
               end
               OP_RESCHED: begin
                  state_in = S_RES_APPLY;
               end
               OP_TICK: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_CUR;
                  state_in   = S_TICK_ADD;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_ACT_EVAL: begin
            cmd.act_commit = 1'b1;
            state_in       = S_DONE;
         end
         S_TICK_ADD: begin
            cmd.tick_commit = 1'b1;
            state_in        = S_RES_APPLY;
         end
         S_RES_APPLY: begin
            if (sts.res_blocked) begin
               state_in = S_DONE;
            end else begin
               cmd.apply_commit = 1'b1;
               cmd.scan_start   = 1'b1;
               state_in         = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_SCAN;
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last scanned entry is compared in this cycle
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick_commit = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/mrts_datapath.sv
// ----------------------------------------------------------------------------
// mrts_datapath
// Task state and runtime tables, running task, slice register, saturating
// runtime adder and the minimum-runtime tracker of the ready-set scan.
// ----------------------------------------------------------------------------
module mrts_datapath
   import mrts_pkg::*;
#(
   parameter int TASK_COUNT   = TASK_COUNT_DEF,
   parameter int RUNTIME_BITS = RUNTIME_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  cmd_type            cmd,
   output sts_type            sts,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SLICE_W-1:0] csr_data
);

   localparam int TASK_BITS = $clog2(TASK_COUNT);
   localparam int ID_W      = (TASK_BITS > TASK_ID_W) ? TASK_BITS : TASK_ID_W;
   localparam int SUM_W     = ((RUNTIME_BITS > SLICE_W) ? RUNTIME_BITS : SLICE_W) + 1;
   localparam logic [TASK_BITS-1:0]    LAST_IDX    = TASK_BITS'(TASK_COUNT - 1);
   localparam logic [RUNTIME_BITS-1:0] RUNTIME_MAX = '1;

   // request and result registers
   req_type              req_ff;
   logic                 acc_ff;
   logic                 sw_ff;
   logic [TASK_BITS-1:0] cur_ff;
   logic [SLICE_W-1:0]   slice_ff;

   // scan and minimum tracking
   logic [TASK_BITS-1:0]    scan_idx_ff;
   logic                    scan_pend_ff;
   logic                    found_ff;
   logic [TASK_BITS-1:0]    best_idx_ff;
   logic [RUNTIME_BITS-1:0] best_rt_ff;

   // task tables
   logic [2:0]              st_mem [TASK_COUNT];
   logic [RUNTIME_BITS-1:0] rt_mem [TASK_COUNT];
   logic [TASK_COUNT-1:0]   st_vld_ff;
   logic [TASK_COUNT-1:0]   rt_vld_ff;
   logic [2:0]              st_rd_ff;
   logic [RUNTIME_BITS-1:0] rt_rd_ff;
   logic                    st_vld_rd_ff;
   logic                    rt_vld_rd_ff;
   logic [TASK_BITS-1:0]    rd_addr_ff;

   logic [ID_W-1:0]         tid_ext;
   logic [ID_W-1:0]         cur_ext;
   logic [TASK_BITS-1:0]    tid_addr;
   logic                    tid_in_range;
   logic [TASK_BITS-1:0]    rd_addr;
   logic [2:0]              st_q;
   logic [RUNTIME_BITS-1:0] rt_q;
   logic                    act_ok;
   logic [2:0]              eff_code;
   logic [SUM_W-1:0]        rt_sum;
   logic [RUNTIME_BITS-1:0] rt_in;
   logic                    st_we;
   logic [TASK_BITS-1:0]    st_wa;
   logic [2:0]              st_wd;
   logic [TASK_BITS-1:0]    next_task;
   logic                    better;

   // task id to table address
   assign tid_ext      = ID_W'(req_ff.task_id);
   assign tid_addr     = tid_ext[TASK_BITS-1:0];
   assign tid_in_range = 32'(req_ff.task_id) < TASK_COUNT;
   assign cur_ext      = ID_W'(cur_ff);

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_TID:  rd_addr = tid_addr;
         RD_CUR:  rd_addr = cur_ff;
         default: rd_addr = scan_idx_ff;
      endcase
   end

   // entries never written read as their reset value
   assign st_q = st_vld_rd_ff ? st_rd_ff
               : ((rd_addr_ff == '0) ? ST_RUNNING : ST_UNUSED);
   assign rt_q = rt_vld_rd_ff ? rt_rd_ff : '0;

   // wake rule
   assign act_ok = tid_in_range &&
                   ((st_q == ST_SLEEPING) || (st_q == ST_UNUSED) ||
                    ((st_q == ST_DEEP) && !req_ff.on_alert));

   // reschedule target and kill check
   assign eff_code = (req_ff.op == OP_TICK) ? ST_RUNNABLE : target_code(req_ff.target_state);

   // saturating runtime add
   assign rt_sum = SUM_W'(rt_q) + SUM_W'(slice_ff);
   assign rt_in  = ((rt_sum >> RUNTIME_BITS) != '0) ? RUNTIME_MAX
                                                    : rt_sum[RUNTIME_BITS-1:0];

   // candidate compare of one scanned entry
   assign better    = (st_q == ST_RUNNABLE) && (!found_ff || (rt_q < best_rt_ff));
   assign next_task = found_ff ? best_idx_ff : '0;

   // state table write port
   always_comb begin
      st_we = 1'b0;
      st_wa = cur_ff;
      st_wd = ST_RUNNING;
      if (cmd.act_commit && act_ok) begin
         st_we = 1'b1;
         st_wa = tid_addr;
         st_wd = ST_RUNNABLE;
      end else if (cmd.apply_commit) begin
         st_we = 1'b1;
         st_wa = cur_ff;
         st_wd = eff_code;
      end else if (cmd.pick_commit) begin
         st_we = 1'b1;
         st_wa = next_task;
         st_wd = ST_RUNNING;
      end
   end

   // table storage and registered read
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_wa] <= st_wd;
      end
      if (cmd.tick_commit) begin
         rt_mem[cur_ff] <= rt_in;
      end
      if (cmd.rd_en) begin
         st_rd_ff     <= st_mem[rd_addr];
         rt_rd_ff     <= rt_mem[rd_addr];
         st_vld_rd_ff <= st_vld_ff[rd_addr];
         rt_vld_rd_ff <= rt_vld_ff[rd_addr];
         rd_addr_ff   <= rd_addr;
      end
   end

   // written-entry flags
   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff <= '0;
         rt_vld_ff <= '0;
      end else begin
         if (st_we) begin
            st_vld_ff[st_wa] <= 1'b1;
         end
         if (cmd.tick_commit) begin
            rt_vld_ff[cur_ff] <= 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         slice_ff     <= SLICE_RESET;
         acc_ff       <= 1'b0;
         sw_ff        <= 1'b0;
         scan_pend_ff <= 1'b0;
         found_ff     <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         if (csr_valid) begin
            slice_ff <= csr_data;
         end
         scan_pend_ff <= cmd.scan_step;
         if (cmd.load_req) begin
            acc_ff <= 1'b0;
            sw_ff  <= 1'b0;
         end
         if (cmd.act_commit) begin
            acc_ff <= act_ok;
         end
         if (cmd.scan_start) begin
            scan_idx_ff <= TASK_BITS'(1);
            found_ff    <= 1'b0;
         end else if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + TASK_BITS'(1);
         end
         if (scan_pend_ff && better) begin
            found_ff <= 1'b1;
         end
         if (cmd.pick_commit) begin
            cur_ff <= next_task;
            acc_ff <= 1'b1;
            sw_ff  <= (next_task != cur_ff);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (scan_pend_ff && better) begin
         best_idx_ff <= rd_addr_ff;
         best_rt_ff  <= rt_q;
      end
   end

   // status and response
   assign sts.op          = req_ff.op;
   assign sts.res_blocked = req_ff.running_killed && (eff_code != ST_ZOMBIE);
   assign sts.scan_last   = (scan_idx_ff == LAST_IDX);

   assign rsp_data.accepted     = acc_ff;
   assign rsp_data.running_task = cur_ext[TASK_ID_W-1:0];
   assign rsp_data.switched     = sw_ff;

   assign csr_ready = 1'b1;

endmodule

>>> rtl/min_runtime_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// min_runtime_task_scheduler_unit
// Single-core task scheduler that runs the ready task of least runtime.
// ----------------------------------------------------------------------------
// Usage: a request is taken at a clock edge with start high and busy low;
// req_data holds op, task_id, on_alert, target_state and running_killed. busy
// stays high until the response, which shows on rsp_data for exactly one
// cycle with rsp_valid high; the receiver cannot stall it, and busy falls
// in the cycle after the strobe.
// An activate reads the task's entry and answers; a tick first adds the slice
// to the running task's runtime and then reschedules; a reschedule scans the
// ready set unless the running task is killed and not made a zombie, when it
// is ignored; an unknown op changes nothing.
// The ready-set scan reads one task table entry per cycle through the single
// read port of the tables.
// A new request may be issued the cycle after the strobe.
// The slice length register is written through csr_valid/csr_data; the user
// must write it only while the block is idle, which the block does not enforce;
// csr_ready is always high.
// Reset: all tasks unused, idle task 0 running, runtimes zero, slice 10; the
// tables need no clearing pass, so a request is taken right after reset.
// ----------------------------------------------------------------------------
module min_runtime_task_scheduler_unit
   import mrts_pkg::*;
#(
   parameter int TASK_COUNT   = TASK_COUNT_DEF,
   parameter int RUNTIME_BITS = RUNTIME_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SLICE_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencing
   mrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables and arithmetic
   mrts_datapath #(
      .TASK_COUNT   (TASK_COUNT),
      .RUNTIME_BITS (RUNTIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

endmodule

>>> rtl/mrts_checker.sv
// ----------------------------------------------------------------------------
// mrts_checker
// Port-level checks of the scheduler's request/response sequencing.
// ----------------------------------------------------------------------------
module mrts_checker
   import mrts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // an accepted transaction keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // the response strobe lasts one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // the block is free again right after its response
   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy held after response");

   // a task switch only comes from an applied reschedule
   a_switch_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.switched) |-> rsp_data.accepted)
      else $error("switch reported without applied reschedule");

endmodule

bind min_runtime_task_scheduler_unit mrts_checker u_mrts_checker (.*);

>>> test/tb_min_runtime_task_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_runtime_task_scheduler_unit
// Self-checking bench for the minimum-runtime task scheduler. A queue of
// requests feeds a driver that honors start/busy with random gaps; a
// scheduler model in the bench predicts every response, and a monitor
// compares each strobed response with the oldest prediction. The slice
// register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_min_runtime_task_scheduler_unit;
   import mrts_pkg::*;

   localparam int TASKS     = TASK_COUNT_DEF;
   localparam int RUNTIME_W = RUNTIME_BITS_DEF;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [SLICE_W-1:0] csr_data = '0;

   min_runtime_task_scheduler_unit #(
      .TASK_COUNT  (TASKS),
      .RUNTIME_BITS(RUNTIME_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   // scheduler model state
   logic [2:0]           sched_state   [TASKS];
   logic [RUNTIME_W-1:0] sched_runtime [TASKS];
   logic [3:0]           sched_current;
   logic [SLICE_W-1:0]   sched_slice;

   req_type pending_req_q[$];
   rsp_type predicted_rsp_q[$];
   int      fail_count = 0;
   int      gap_left   = 0;
   bit      req_taken  = 1'b0;

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #200_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ready task of least runtime, lower number on ties, idle when none
   function automatic logic [3:0] least_runtime_task();
      logic [3:0] best;
      bit         found;
      best  = '0;
      found = 1'b0;
      for (int i = 1; i < TASKS; i++) begin
         if (sched_state[i] == ST_RUNNABLE &&
             (!found || sched_runtime[i] < sched_runtime[best])) begin
            best  = i[3:0];
            found = 1'b1;
         end
      end
      return best;
   endfunction

   // give the running task its new state and dispatch the next one
   function automatic bit reschedule_current(logic [1:0] tgt, logic killed);
      logic [2:0] code;
      logic [3:0] next;
      case (tgt)
         TGT_RUNNABLE: code = ST_RUNNABLE;
         TGT_SLEEPING: code = ST_SLEEPING;
         TGT_DEEP:     code = ST_DEEP;
         default:      code = ST_ZOMBIE;
      endcase
      if (killed && code != ST_ZOMBIE) return 1'b0;
      sched_state[sched_current] = code;
      next = least_runtime_task();
      sched_state[next] = ST_RUNNING;
      sched_current = next;
      return 1'b1;
   endfunction

   // apply one request to the model and return the response it produces
   function automatic rsp_type schedule_request(req_type r);
      rsp_type          o;
      logic [3:0]       was;
      logic [2:0]       s;
      logic [RUNTIME_W:0] sum;
      o   = '0;
      was = sched_current;
      case (r.op)
         OP_ACTIVATE: begin
            s = sched_state[r.task_id];
            if (s == ST_SLEEPING || s == ST_UNUSED || (s == ST_DEEP && !r.on_alert)) begin
               sched_state[r.task_id] = ST_RUNNABLE;
               o.accepted = 1'b1;
            end
         end
         OP_RESCHED: o.accepted = reschedule_current(r.target_state, r.running_killed);
         OP_TICK: begin
            sum = {1'b0, sched_runtime[sched_current]} + sched_slice;
            sched_runtime[sched_current] = sum[RUNTIME_W] ? '1 : sum[RUNTIME_W-1:0];
            o.accepted = reschedule_current(TGT_RUNNABLE, r.running_killed);
         end
         default: ;
      endcase
      o.running_task = sched_current;
      o.switched     = (sched_current != was);
      return o;
   endfunction

   // request driver, changes at the falling edge
   always @(negedge clock) begin
      int roll;
      if (!reset && !(start && !req_taken)) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_req_q.size() > 0) begin
            req_data <= pending_req_q.pop_front();
            start    <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 45) gap_left = 0;
            else if (roll < 90) gap_left = $urandom_range(1, 3);
            else gap_left = $urandom_range(8, 40);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // accepted request transaction: predict its response
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         predicted_rsp_q.push_back(schedule_request(req_data));
         req_taken = 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (predicted_rsp_q.size() == 0) begin
            $error("response with nothing predicted: %p", rsp_data);
            fail_count++;
         end else begin
            want = predicted_rsp_q.pop_front();
            if (rsp_data.accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_data.accepted);
               fail_count++;
            end
            if (rsp_data.running_task !== want.running_task) begin
               $error("running_task: expected %0d, got %0d",
                      want.running_task, rsp_data.running_task);
               fail_count++;
            end
            if (rsp_data.switched !== want.switched) begin
               $error("switched: expected %0d, got %0d", want.switched, rsp_data.switched);
               fail_count++;
            end
         end
      end
   end

   task automatic queue_req(logic [1:0] op, logic [3:0] tid, logic alert,
                            logic [1:0] tgt, logic killed);
      req_type r;
      r.op             = op;
      r.task_id        = tid;
      r.on_alert       = alert;
      r.target_state   = tgt;
      r.running_killed = killed;
      pending_req_q.push_back(r);
   endtask

   // mostly activates, reschedules and ticks; zombie targets kept rare
   // since a zombie task can never be woken again
   task automatic queue_random_reqs(int count);
      int         roll;
      logic [1:0] op;
      logic [1:0] tgt;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) op = OP_ACTIVATE;
         else if (roll < 65) op = OP_RESCHED;
         else if (roll < 95) op = OP_TICK;
         else op = OP_UNKNOWN;
         tgt = 2'($urandom_range(0, 2));
         if ($urandom_range(0, 59) == 0) tgt = TGT_ZOMBIE;
         queue_req(op, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), tgt,
                   $urandom_range(0, 99) < 15);
      end
   endtask

   // wait until every request is taken and every response has come back
   task automatic wait_idle();
      while (pending_req_q.size() != 0 || start || predicted_rsp_q.size() != 0 || busy)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_slice(logic [SLICE_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sched_slice = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stimulus and end of run
   initial begin
      for (int i = 0; i < TASKS; i++) begin
         sched_state[i]   = ST_UNUSED;
         sched_runtime[i] = '0;
      end
      sched_state[0] = ST_RUNNING;
      sched_current  = '0;
      sched_slice    = SLICE_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed sequence at the reset slice length
      queue_req(OP_ACTIVATE, 4'd0,  1'b0, TGT_RUNNABLE, 1'b0);  // idle while running
      queue_req(OP_RESCHED,  4'd0,  1'b0, TGT_RUNNABLE, 1'b0);  // nothing ready
      queue_req(OP_ACTIVATE, 4'd0,  1'b0, TGT_RUNNABLE, 1'b0);  // idle running again
      queue_req(OP_ACTIVATE, 4'd3,  1'b1, TGT_RUNNABLE, 1'b0);
      queue_req(OP_ACTIVATE, 4'd15, 1'b0, TGT_RUNNABLE, 1'b0);
      queue_req(OP_ACTIVATE, 4'd3,  1'b0, TGT_RUNNABLE, 1'b0);  // already runnable
      queue_req(OP_TICK,     4'd0,  1'b0, TGT_RUNNABLE, 1'b0);  // tie goes to task 3
      queue_req(OP_RESCHED,  4'd0,  1'b0, TGT_DEEP,     1'b0);
      queue_req(OP_ACTIVATE, 4'd3,  1'b1, TGT_RUNNABLE, 1'b0);  // deep sleep on alert
      queue_req(OP_ACTIVATE, 4'd3,  1'b0, TGT_RUNNABLE, 1'b0);
      queue_req(OP_TICK,     4'd0,  1'b0, TGT_RUNNABLE, 1'b1);  // killed tick still adds
      queue_req(OP_RESCHED,  4'd0,  1'b0, TGT_SLEEPING, 1'b1);  // killed, ignored
      queue_req(OP_RESCHED,  4'd0,  1'b0, TGT_ZOMBIE,   1'b1);  // killed to zombie
      queue_req(OP_ACTIVATE, 4'd15, 1'b0, TGT_RUNNABLE, 1'b0);  // zombie refused
      queue_req(OP_UNKNOWN,  4'd15, 1'b1, TGT_ZOMBIE,   1'b1);
      queue_req(OP_RESCHED,  4'd0,  1'b0, TGT_SLEEPING, 1'b0);
      queue_req(OP_ACTIVATE, 4'd3,  1'b0, TGT_RUNNABLE, 1'b0);
      queue_req(OP_ACTIVATE, 4'd8,  1'b1, TGT_RUNNABLE, 1'b0);
      queue_req(OP_ACTIVATE, 4'd9,  1'b0, TGT_RUNNABLE, 1'b0);
      queue_req(OP_TICK,     4'd0,  1'b0, TGT_RUNNABLE, 1'b0);
      queue_req(OP_TICK,     4'd0,  1'b0, TGT_RUNNABLE, 1'b0);
      queue_req(OP_RESCHED,  4'd0,  1'b0, TGT_ZOMBIE,   1'b0);
      queue_req(OP_RESCHED,  4'd0,  1'b0, TGT_RUNNABLE, 1'b0);
      queue_req(OP_TICK,     4'd0,  1'b0, TGT_RUNNABLE, 1'b0);
      queue_random_reqs(100);

      // random phases over several slice lengths, extremes included
      write_slice(16'd1);
      queue_random_reqs(400);
      write_slice(16'hFFFF);
      queue_random_reqs(400);
      write_slice(16'd0);
      queue_random_reqs(250);
      write_slice(SLICE_W'($urandom_range(2, 16'hFFFE)));
      queue_random_reqs(650);

      wait_idle();
      repeat (30) @(posedge clock);
      if (fail_count == 0 && predicted_rsp_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
